// ===== design/ibwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverse BWT block decoder package
// Shared sizes, codes and item types for the inverse BWT block decoder.
// ----------------------------------------------------------------------------
package ibwt_pkg;

	localparam int MAX_BLOCK = 1048576;
	localparam int IDX_W     = $clog2(MAX_BLOCK);
	localparam int LEN_W     = IDX_W + 1;
	localparam int POS_W     = 20;
	localparam int CHAIN_W   = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int CMP_W     = CHAIN_W + 1;
	localparam int SYM_W     = 8;
	localparam int NUM_SYM   = 256;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef enum logic [1:0] {
		PH_LOADING,
		PH_DRAINING,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_BASE,
		ST_EMIT_SYM,
		ST_EMIT_CHAIN
	} state_t;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       in_byte;
		logic             is_last;
		logic [POS_W-1:0] start_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [POS_W-1:0] out_pos;
		logic             last_out;
		logic             bad_start;
	} out_item_t;

	typedef struct packed {
		logic             clear;
		logic             rd_en;
		logic [SYM_W-1:0] rd_addr;
		logic             wr_en;
		logic [SYM_W-1:0] wr_addr;
		logic [LEN_W-1:0] wr_data;
	} cnt_req_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] rank;
	} store_entry_t;

endpackage

// ===== design/ibwt_count_table.sv =====
// ----------------------------------------------------------------------------
// Inverse BWT symbol count table
// Holds one count per symbol while loading and one base per symbol while
// draining. Valid bits make a cleared entry read as zero.
// ----------------------------------------------------------------------------
module ibwt_count_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ibwt_pkg::cnt_req_t                 req,
	output logic [ibwt_pkg::LEN_W-1:0]         rd_data
);
	import ibwt_pkg::*;

	logic [LEN_W-1:0]   cnt_mem [NUM_SYM];
	logic [NUM_SYM-1:0] vld_q;
	logic               rd_vld_q;
	logic [LEN_W-1:0]   mem_dout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr] & ~req.clear;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			cnt_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_dout_q <= cnt_mem[req.rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? mem_dout_q : '0;

endmodule

// ===== design/inverse_bwt_block_decoder.sv =====
// ----------------------------------------------------------------------------
// Inverse BWT block decoder
// Loads one transformed block byte by byte, turns the symbol counts into
// bases, then walks the chain one decoded byte per emit command.
//
//   channel   signals               handshake
//   --------  --------------------  ------------------------------------
//   command   start, busy, item     taken when start is high, busy low
//   result    valid, result         one-cycle strobe, cannot be stalled
//
// A load reads the count, then writes back the count and the store entry.
// The final load adds a base sweep over the 256-entry count table. An emit
// does a store read, a base read, then a chain update; a bad start index
// answers with no chain step. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module inverse_bwt_block_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ibwt_pkg::in_item_t  item,
	output logic                valid,
	output ibwt_pkg::out_item_t result
);
	import ibwt_pkg::*;

	state_t             state_q, state_d;
	phase_t             phase_q;
	logic [LEN_W-1:0]   len_q;
	logic [CHAIN_W-1:0] chain_q;
	logic [LEN_W-1:0]   pos_q;
	logic [SYM_W:0]     sweep_q;
	logic [LEN_W-1:0]   running_q;
	logic               swp_wr_s1;
	logic [SYM_W-1:0]   swp_addr_s1;
	logic [SYM_W-1:0]   ld_byte_q;
	logic               ld_last_q;
	logic [POS_W-1:0]   ld_start_q;
	store_entry_t       store_mem [MAX_BLOCK];
	store_entry_t       store_rd_q;
	out_item_t          res_q;
	logic               valid_q;

	cnt_req_t           cnt_req;
	logic [LEN_W-1:0]   cnt_rd;
	logic               accept;
	logic               room;
	logic               bad_emit;
	logic               store_we;
	logic               store_re;

	ibwt_count_table u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_data (cnt_rd)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & ~busy;
	assign room     = (len_q < LEN_W'(MAX_BLOCK));
	assign bad_emit = (CMP_W'(chain_q) >= CMP_W'(len_q)) || (pos_q == '0);
	assign store_we = (state_q == ST_LOAD) && room;
	assign store_re = accept && (item.cmd == CMD_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.cmd == CMD_LOAD) begin
						cnt_req.clear   = (phase_q != PH_LOADING);
						cnt_req.rd_en   = 1'b1;
						cnt_req.rd_addr = item.in_byte;
						state_d         = ST_LOAD;
					end else if (phase_q == PH_DRAINING && !bad_emit) begin
						state_d = ST_EMIT_SYM;
					end
				end
			end
			ST_LOAD: begin
				if (room) begin
					cnt_req.wr_en   = 1'b1;
					cnt_req.wr_addr = ld_byte_q;
					cnt_req.wr_data = cnt_rd + LEN_W'(1);
				end
				state_d = ld_last_q ? ST_BASE : ST_IDLE;
			end
			ST_BASE: begin
				if (!sweep_q[SYM_W]) begin
					cnt_req.rd_en   = 1'b1;
					cnt_req.rd_addr = sweep_q[SYM_W-1:0];
				end
				if (swp_wr_s1) begin
					cnt_req.wr_en   = 1'b1;
					cnt_req.wr_addr = swp_addr_s1;
					cnt_req.wr_data = running_q;
				end
				if (sweep_q[SYM_W] && !swp_wr_s1) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_SYM: begin
				cnt_req.rd_en   = 1'b1;
				cnt_req.rd_addr = store_rd_q.sym;
				state_d         = ST_EMIT_CHAIN;
			end
			ST_EMIT_CHAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LOADING;
			len_q     <= '0;
			chain_q   <= '0;
			pos_q     <= '0;
			sweep_q   <= '0;
			running_q <= '0;
			swp_wr_s1 <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			valid_q   <= 1'b0;
			swp_wr_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == CMD_LOAD && phase_q != PH_LOADING) begin
						phase_q <= PH_LOADING;
						len_q   <= '0;
					end
					if (accept && item.cmd == CMD_EMIT && phase_q == PH_DRAINING &&
					    bad_emit) begin
						phase_q <= PH_DONE;
						valid_q <= 1'b1;
					end
				end
				ST_LOAD: begin
					if (room) begin
						len_q <= len_q + LEN_W'(1);
					end
					sweep_q   <= '0;
					running_q <= '0;
				end
				ST_BASE: begin
					if (!sweep_q[SYM_W]) begin
						sweep_q   <= sweep_q + (SYM_W+1)'(1);
						swp_wr_s1 <= 1'b1;
					end
					if (swp_wr_s1) begin
						running_q <= running_q + cnt_rd;
					end
					if (sweep_q[SYM_W] && !swp_wr_s1) begin
						chain_q <= CHAIN_W'(ld_start_q);
						pos_q   <= len_q;
						phase_q <= PH_DRAINING;
					end
				end
				ST_EMIT_CHAIN: begin
					chain_q <= CHAIN_W'(cnt_rd + LEN_W'(store_rd_q.rank));
					pos_q   <= pos_q - LEN_W'(1);
					valid_q <= 1'b1;
					if (pos_q == LEN_W'(1)) begin
						phase_q <= PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_LOAD) begin
			ld_byte_q  <= item.in_byte;
			ld_last_q  <= item.is_last;
			ld_start_q <= item.start_index;
		end
		if (state_q == ST_BASE) begin
			swp_addr_s1 <= sweep_q[SYM_W-1:0];
		end
		if (state_q == ST_IDLE && accept && item.cmd == CMD_EMIT) begin
			res_q.out_byte  <= '0;
			res_q.out_pos   <= '0;
			res_q.last_out  <= 1'b1;
			res_q.bad_start <= 1'b1;
		end else if (state_q == ST_EMIT_CHAIN) begin
			res_q.out_byte  <= store_rd_q.sym;
			res_q.out_pos   <= POS_W'(pos_q - LEN_W'(1));
			res_q.last_out  <= (pos_q == LEN_W'(1));
			res_q.bad_start <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[len_q[IDX_W-1:0]] <= '{sym: ld_byte_q, rank: cnt_rd[IDX_W-1:0]};
		end
		if (store_re) begin
			store_rd_q <= store_mem[chain_q[IDX_W-1:0]];
		end
	end

	assign valid  = valid_q;
	assign result = res_q;

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (state_q == ST_IDLE))
		else $error("A result item left while an item was still in work.");

	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |=> !valid_q)
		else $error("Two result items came out in adjacent cycles.");

	a_base_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BASE && state_d == ST_IDLE) |-> (running_q == len_q))
		else $error("The symbol bases do not add up to the block length.");

	a_chain_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_SYM || state_q == ST_EMIT_CHAIN) |->
		(phase_q == PH_DRAINING))
		else $error("A chain step ran outside the draining phase.");

endmodule
